// ----- rtl/core/bfi_pkg.sv -----
package bfi_pkg;

  localparam int unsigned BYTE_W = 8;

  // Instruction characters.
  localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] OP_PRINT = 8'h2E;  // '.'
  localparam logic [BYTE_W-1:0] OP_READ  = 8'h2C;  // ','
  localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;  // ']'

  // Command codes of an input item.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              input_taken;
    logic              halted;
    logic              bracket_error;
  } bfi_res_t;

endpackage

// ----- rtl/core/bfi_chan_if.sv -----
interface bfi_in_if;
  import bfi_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] data_byte;
  logic              input_available;

  modport source (output valid, command, data_byte, input_available, input ready);
  modport sink   (input valid, command, data_byte, input_available, output ready);
endinterface

interface bfi_out_if;
  import bfi_pkg::*;

  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              input_taken;
  logic              halted;
  logic              bracket_error;

  modport source (output valid, out_valid, out_byte, input_taken, halted, bracket_error,
                  input ready);
  modport sink   (input valid, out_valid, out_byte, input_taken, halted, bracket_error,
                  output ready);
endinterface

// ----- rtl/core/brainfuck_interpreter_step.sv -----
// Channel   Direction  Handshake          Payload
// in_ch     sink       valid/ready        command, data_byte, input_available
// out_ch    source     valid/ready        out_valid, out_byte, input_taken, halted,
//                                         bracket_error
//
// A load item finishes in the state that accepts it; a simple step reads the
// program and tape in ST_IDLE, then executes and writes back in ST_EXEC; a step
// while halted finishes on acceptance. A bracket scan passes ST_SCAN_RD and
// ST_SCAN_CHK for each program byte visited, set by the single program store
// read port, and ST_SCAN_RD once more when it runs off either end of the store.
// After reset the tape is cleared one cell per cycle, with in_ch.ready low.
// One item is in flight at a time; a finished item waits in the output register
// while the next one is accepted, and a stalled out_ch holds the following result.

module brainfuck_interpreter_step #(
  parameter int unsigned PROGRAM_DEPTH = 65536,
  parameter int unsigned TAPE_DEPTH    = 4096,
  parameter int unsigned CELL_WIDTH    = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bfi_in_if.sink     in_ch,
  bfi_out_if.source  out_ch
);
  import bfi_pkg::*;

  // Program addresses, with one extra bit so the counter can sit at the end.
  localparam int unsigned AW  = $clog2(PROGRAM_DEPTH);
  localparam int unsigned PCW = AW + 1;
  localparam int unsigned TW  = $clog2(TAPE_DEPTH);
  localparam logic [PCW-1:0] PC_END   = PCW'(PROGRAM_DEPTH);
  localparam logic [TW-1:0]  TP_LAST  = TW'(TAPE_DEPTH - 1);
  localparam logic [CELL_WIDTH-1:0] LOW_MASK = CELL_WIDTH'(8'hFF);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PUT
  } state_t;

  // Storage.
  logic [BYTE_W-1:0]     prog_mem [PROGRAM_DEPTH];
  logic [CELL_WIDTH-1:0] tape_mem [TAPE_DEPTH];

  // Registers.
  state_t            state_r, state_nxt;
  logic [PCW-1:0]    pc_r, pc_nxt;
  logic [TW-1:0]     tp_r, tp_nxt;
  logic [PCW-1:0]    load_pos_r, load_pos_nxt;
  logic              err_r, err_nxt;
  logic [TW-1:0]     clr_r, clr_nxt;
  logic [PCW-1:0]    scan_p_r, scan_p_nxt;
  logic [PCW-1:0]    scan_d_r, scan_d_nxt;
  logic              scan_fwd_r, scan_fwd_nxt;
  logic [BYTE_W-1:0] in_data_r, in_data_nxt;
  logic              in_avail_r, in_avail_nxt;
  bfi_res_t          res_r, res_nxt;
  bfi_res_t          out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  // Memory ports.
  logic              prog_we, prog_re, prog_hit_r;
  logic [AW-1:0]     prog_wa, prog_ra;
  logic [BYTE_W-1:0] prog_q;
  logic              tape_we, tape_re;
  logic [TW-1:0]     tape_wa;
  logic [CELL_WIDTH-1:0] tape_wd, tape_q;

  // Datapath helpers.
  logic              fin;
  bfi_res_t          res_fin;
  logic              slot_free;
  logic [BYTE_W-1:0] opcode;
  logic [PCW-1:0]    scan_d_new;
  logic [PCW-1:0]    scan_p_dec;

  // The program store only ever grows by appending and has no reset, so every read
  // at or past the load position is forced to zero through prog_hit_r.
  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[prog_wa] <= in_ch.data_byte;
    end
    if (prog_re) begin
      prog_q     <= prog_mem[prog_ra];
      prog_hit_r <= ({1'b0, prog_ra} < load_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    if (tape_re) begin
      tape_q <= tape_mem[tp_r];
    end
  end

  assign opcode     = prog_hit_r ? prog_q : '0;
  assign slot_free  = !out_vld_r || out_ch.ready;
  assign scan_p_dec = scan_p_r - PCW'(1);

  // Bracket depth after the byte just read: the bracket of the scan's own kind
  // nests deeper, the other kind closes one level.
  always_comb begin
    scan_d_new = scan_d_r;
    if ((scan_fwd_r && opcode == OP_CLOSE) || (!scan_fwd_r && opcode == OP_OPEN)) begin
      scan_d_new = scan_d_r - PCW'(1);
    end else if ((scan_fwd_r && opcode == OP_OPEN) ||
                 (!scan_fwd_r && opcode == OP_CLOSE)) begin
      scan_d_new = scan_d_r + PCW'(1);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    tp_nxt       = tp_r;
    load_pos_nxt = load_pos_r;
    err_nxt      = err_r;
    clr_nxt      = clr_r;
    scan_p_nxt   = scan_p_r;
    scan_d_nxt   = scan_d_r;
    scan_fwd_nxt = scan_fwd_r;
    in_data_nxt  = in_data_r;
    in_avail_nxt = in_avail_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;

    prog_we = 1'b0;
    prog_wa = load_pos_r[AW-1:0];
    prog_re = 1'b0;
    prog_ra = pc_r[AW-1:0];
    tape_we = 1'b0;
    tape_wa = tp_r;
    tape_wd = '0;
    tape_re = 1'b0;

    fin     = 1'b0;
    res_fin = '0;

    unique case (state_r)
      ST_CLEAR: begin
        tape_we = 1'b1;
        tape_wa = clr_r;
        clr_nxt = clr_r + TW'(1);
        if (clr_r == TP_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == CMD_LOAD) begin
            if (load_pos_r < PC_END) begin
              prog_we      = 1'b1;
              load_pos_nxt = load_pos_r + PCW'(1);
            end
            fin = 1'b1;
          end else if (pc_r >= PC_END) begin
            fin = 1'b1;
          end else begin
            prog_re      = 1'b1;
            tape_re      = 1'b1;
            in_data_nxt  = in_ch.data_byte;
            in_avail_nxt = in_ch.input_available;
            state_nxt    = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        fin    = 1'b1;
        pc_nxt = pc_r + PCW'(1);
        unique case (opcode)
          OP_LEFT: begin
            tp_nxt = (tp_r == '0) ? TP_LAST : tp_r - TW'(1);
          end
          OP_RIGHT: begin
            tp_nxt = (tp_r == TP_LAST) ? '0 : tp_r + TW'(1);
          end
          OP_INC: begin
            tape_we = 1'b1;
            tape_wd = tape_q + CELL_WIDTH'(1);
          end
          OP_DEC: begin
            tape_we = 1'b1;
            tape_wd = tape_q - CELL_WIDTH'(1);
          end
          OP_PRINT: begin
            res_fin.out_valid = 1'b1;
            res_fin.out_byte  = tape_q[BYTE_W-1:0];
          end
          OP_READ: begin
            if (in_avail_r) begin
              tape_we             = 1'b1;
              tape_wd             = (tape_q & ~LOW_MASK) | CELL_WIDTH'(in_data_r);
              res_fin.input_taken = 1'b1;
            end
          end
          OP_OPEN: begin
            if (tape_q == '0) begin
              fin          = 1'b0;
              pc_nxt       = pc_r;
              scan_p_nxt   = pc_r + PCW'(1);
              scan_d_nxt   = PCW'(1);
              scan_fwd_nxt = 1'b1;
              state_nxt    = ST_SCAN_RD;
            end
          end
          OP_CLOSE: begin
            if (tape_q != '0) begin
              fin          = 1'b0;
              pc_nxt       = pc_r;
              scan_p_nxt   = pc_r;
              scan_d_nxt   = PCW'(1);
              scan_fwd_nxt = 1'b0;
              state_nxt    = ST_SCAN_RD;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN_RD: begin
        // Running off either end of the store is an unmatched bracket.
        if ((scan_fwd_r && scan_p_r >= PC_END) || (!scan_fwd_r && scan_p_r == '0)) begin
          err_nxt = 1'b1;
          pc_nxt  = PC_END;
          fin     = 1'b1;
        end else begin
          prog_re   = 1'b1;
          state_nxt = ST_SCAN_CHK;
          if (scan_fwd_r) begin
            prog_ra = scan_p_r[AW-1:0];
          end else begin
            prog_ra    = scan_p_dec[AW-1:0];
            scan_p_nxt = scan_p_dec;
          end
        end
      end

      ST_SCAN_CHK: begin
        scan_d_nxt = scan_d_new;
        if (scan_d_new == '0) begin
          pc_nxt = scan_p_r + PCW'(1);
          fin    = 1'b1;
        end else begin
          if (scan_fwd_r) begin
            scan_p_nxt = scan_p_r + PCW'(1);
          end
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_PUT: begin
        if (slot_free) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Status flags report the state after this item.
    res_fin.halted        = (pc_nxt >= PC_END);
    res_fin.bracket_error = err_nxt;

    if (fin) begin
      if (slot_free) begin
        out_nxt     = res_fin;
        out_vld_nxt = 1'b1;
        state_nxt   = ST_IDLE;
      end else begin
        res_nxt   = res_fin;
        state_nxt = ST_PUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      pc_r       <= '0;
      tp_r       <= '0;
      load_pos_r <= '0;
      err_r      <= 1'b0;
      clr_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pc_r       <= pc_nxt;
      tp_r       <= tp_nxt;
      load_pos_r <= load_pos_nxt;
      err_r      <= err_nxt;
      clr_r      <= clr_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    scan_p_r   <= scan_p_nxt;
    scan_d_r   <= scan_d_nxt;
    scan_fwd_r <= scan_fwd_nxt;
    in_data_r  <= in_data_nxt;
    in_avail_r <= in_avail_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_vld_r;
  assign out_ch.out_valid     = out_r.out_valid;
  assign out_ch.out_byte      = out_r.out_byte;
  assign out_ch.input_taken   = out_r.input_taken;
  assign out_ch.halted        = out_r.halted;
  assign out_ch.bracket_error = out_r.bracket_error;

  // A step that executes keeps the input closed while it is worked on.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_STEP && pc_r < PC_END)
      |=> !in_ch.ready)
    else $error("item accepted while another is in flight");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_END)
    else $error("program counter past the end of the store");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (pc_r == PC_END))
    else $error("bracket error without halt");

  a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (load_pos_r >= $past(load_pos_r)))
    else $error("load position moved backward");

  a_tp_range: assert property (@(posedge clk) disable iff (!rst_n)
    tp_r <= TP_LAST)
    else $error("tape pointer out of range");

endmodule

// ----- bench/tb_brainfuck_interpreter_step.sv -----
module tb_brainfuck_interpreter_step;
  timeunit 1ns;
  timeprecision 1ps;

  import bfi_pkg::*;

  // Block configuration. The bench predicts the default sizes of the block.
  localparam int PROG_DEPTH = 65536;
  localparam int TAPE_DEPTH = 4096;
  localparam int CELL_W     = 32;
  localparam int PC_W       = $clog2(PROG_DEPTH) + 1;
  localparam int PTR_W      = $clog2(TAPE_DEPTH);

  // Run length and flow control. About 850 random items follow the directed
  // part. The closing phase then loads a short program whose unmatched bracket
  // scan runs through the empty rest of the store to its end. Even with idling
  // on both sides, the cycle limit leaves a wide margin over the whole run.
  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_PCT     = 21;
  localparam int READ_PCT     = 85;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int TAIL_CYCLES  = 50;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data_byte;
    logic              input_available;
  } bf_item_t;

  logic clk;
  logic rst_n;

  bfi_in_if  in_if ();
  bfi_out_if out_if ();

  brainfuck_interpreter_step #(
    .PROGRAM_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH    (TAPE_DEPTH),
    .CELL_WIDTH    (CELL_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = ~clk;
  end

  // Items waiting to be driven, results still owed by the block, and the
  // program text of the block that the generator is building.
  bf_item_t          pending_items [$];
  bfi_res_t          expected_results [$];
  logic [BYTE_W-1:0] program_buf [$];
  bf_item_t          driven_item;
  bfi_res_t          want_res;

  int  items_queued;
  int  mismatch_count;
  int  cycle_count;
  bit  steady_flow;

  // Interpreter state as the bench sees it. It advances when the block
  // accepts an item, so it always describes the block after the last accepted
  // item and before the ones still queued.
  logic [BYTE_W-1:0] program_mem [PROG_DEPTH];
  logic [CELL_W-1:0] tape_cells [TAPE_DEPTH];
  logic [PC_W-1:0]   exec_pc;
  logic [PC_W-1:0]   load_ptr;
  logic [PTR_W-1:0]  cell_ptr;
  logic              scan_failed;

  // Apply one accepted item to the interpreter state and queue the result the
  // block owes for it. Every item, load or step, produces exactly one result.
  function automatic void predict_item(input bf_item_t it);
    bfi_res_t          r;
    logic [CELL_W-1:0] cur_cell;
    int                next_pc;
    int                p;
    int                depth;
    bit                done;
    r = '0;
    if (it.command == CMD_LOAD) begin
      // A full store silently drops the byte.
      if (load_ptr < PROG_DEPTH) begin
        program_mem[load_ptr] = it.data_byte;
        load_ptr = load_ptr + 1'b1;
      end
    end else if (exec_pc < PROG_DEPTH) begin
      cur_cell = tape_cells[cell_ptr];
      next_pc  = exec_pc + 1;
      case (program_mem[exec_pc])
        OP_LEFT:  cell_ptr = cell_ptr - 1'b1;
        OP_RIGHT: cell_ptr = cell_ptr + 1'b1;
        OP_INC:   tape_cells[cell_ptr] = cur_cell + 1'b1;
        OP_DEC:   tape_cells[cell_ptr] = cur_cell - 1'b1;
        OP_PRINT: begin
          r.out_valid = 1'b1;
          r.out_byte  = cur_cell[BYTE_W-1:0];
        end
        OP_READ: begin
          // At end of input the cell keeps its value.
          if (it.input_available) begin
            tape_cells[cell_ptr] = {cur_cell[CELL_W-1:BYTE_W], it.data_byte};
            r.input_taken = 1'b1;
          end
        end
        OP_OPEN: begin
          // Zero cell: skip forward past the matching close bracket.
          if (cur_cell == '0) begin
            p     = exec_pc;
            depth = 1;
            done  = 1'b0;
            while (!done) begin
              p++;
              if (p >= PROG_DEPTH) begin
                scan_failed = 1'b1;
                next_pc     = PROG_DEPTH;
                done        = 1'b1;
              end else begin
                if (program_mem[p] == OP_CLOSE) depth--;
                else if (program_mem[p] == OP_OPEN) depth++;
                if (depth == 0) begin
                  next_pc = p + 1;
                  done    = 1'b1;
                end
              end
            end
          end
        end
        OP_CLOSE: begin
          // Nonzero cell: go back to just after the matching open bracket.
          if (cur_cell != '0) begin
            p     = exec_pc;
            depth = 1;
            done  = 1'b0;
            while (!done) begin
              if (p == 0) begin
                scan_failed = 1'b1;
                next_pc     = PROG_DEPTH;
                done        = 1'b1;
              end else begin
                p--;
                if (program_mem[p] == OP_OPEN) depth--;
                else if (program_mem[p] == OP_CLOSE) depth++;
                if (depth == 0) begin
                  next_pc = p + 1;
                  done    = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      exec_pc = PC_W'(next_pc);
    end
    r.halted        = (exec_pc >= PROG_DEPTH);
    r.bracket_error = scan_failed;
    expected_results.push_back(r);
  endfunction

  task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver. When the current item has been taken, or nothing is on the bus,
  // the next queued item goes out unless the sender decides to idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_item(driven_item);
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
          driven_item = pending_items.pop_front();
          in_if.valid           <= 1'b1;
          in_if.command         <= driven_item.command;
          in_if.data_byte       <= driven_item.data_byte;
          in_if.input_available <= driven_item.input_available;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result taken from the block is matched against the oldest
  // expectation; ready drops at random to stall the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result item with nothing expected", $time);
          mismatch_count++;
        end else begin
          want_res = expected_results.pop_front();
          compare_field("out_valid", want_res.out_valid, out_if.out_valid);
          compare_field("out_byte", want_res.out_byte, out_if.out_byte);
          compare_field("input_taken", want_res.input_taken, out_if.input_taken);
          compare_field("halted", want_res.halted, out_if.halted);
          compare_field("bracket_error", want_res.bracket_error, out_if.bracket_error);
        end
      end
      out_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // The cycle limit only trips if the block hangs or loses results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("brainfuck_interpreter_step test failed");
      $finish;
    end
  end

  task automatic push_load(input logic [BYTE_W-1:0] b);
    bf_item_t it;
    it.command         = CMD_LOAD;
    it.data_byte       = b;
    it.input_available = 1'b0;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_step(input logic [BYTE_W-1:0] d, input logic avail);
    bf_item_t it;
    it.command         = CMD_STEP;
    it.data_byte       = d;
    it.input_available = avail;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_step_rand();
    push_step(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 99) < READ_PCT);
  endtask

  // Any byte but a bracket, so it can never unbalance a program.
  function automatic logic [BYTE_W-1:0] filler_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == OP_OPEN || b == OP_CLOSE);
    return b;
  endfunction

  // The generator samples at the falling edge, after the driver's updates of
  // the rising edge have settled.
  function automatic bit sender_idle();
    return pending_items.size() == 0 && !in_if.valid;
  endfunction

  task automatic wait_drained();
    while (!sender_idle() || expected_results.size() != 0) @(negedge clk);
  endtask

  // Build one balanced program fragment. Loops are walks along the tape that
  // stop at the first zero cell, so they always end on a mostly empty tape;
  // the nested form also drives the bracket depth counting in both scans.
  task automatic build_block();
    int                pick;
    logic [BYTE_W-1:0] move;
    program_buf.delete();
    repeat ($urandom_range(4, 14)) begin
      pick = $urandom_range(0, 99);
      move = $urandom_range(0, 1) ? OP_RIGHT : OP_LEFT;
      if (pick < 14) program_buf.push_back(OP_INC);
      else if (pick < 26) program_buf.push_back(OP_DEC);
      else if (pick < 38) program_buf.push_back(move);
      else if (pick < 50) program_buf.push_back(OP_PRINT);
      else if (pick < 60) program_buf.push_back(OP_READ);
      else if (pick < 68) program_buf.push_back(filler_byte());
      else if (pick < 86) begin
        program_buf.push_back(OP_OPEN);
        case ($urandom_range(0, 4))
          0: program_buf.push_back(OP_INC);
          1: program_buf.push_back(OP_DEC);
          2: program_buf.push_back(OP_PRINT);
          3: program_buf.push_back(OP_READ);
          default: ;
        endcase
        program_buf.push_back(move);
        program_buf.push_back(OP_CLOSE);
      end else begin
        program_buf.push_back(OP_OPEN);
        program_buf.push_back(OP_OPEN);
        program_buf.push_back(move);
        program_buf.push_back(OP_CLOSE);
        program_buf.push_back(move);
        program_buf.push_back(OP_CLOSE);
      end
    end
  endtask

  // Feed step items until execution catches up with the loaded program. One
  // step stays queued behind the one on the bus, so the counter may run a
  // step or two past the loaded bytes into the empty store, which is harmless.
  task automatic run_program(input int budget);
    int left;
    left = budget;
    while (!sender_idle()) @(negedge clk);
    while (exec_pc < load_ptr && left > 0) begin
      while (pending_items.size() != 0) @(negedge clk);
      push_step_rand();
      left--;
    end
  endtask

  initial begin
    int directed_total;
    int blk;

    clk            = 1'b0;
    rst_n          = 1'b0;
    steady_flow    = 1'b0;
    items_queued   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    in_if.valid           = 1'b0;
    in_if.command         = CMD_LOAD;
    in_if.data_byte       = '0;
    in_if.input_available = 1'b0;
    out_if.ready          = 1'b0;

    foreach (program_mem[i]) program_mem[i] = '0;
    foreach (tape_cells[i]) tape_cells[i] = '0;
    exec_pc     = '0;
    load_ptr    = '0;
    cell_ptr    = '0;
    scan_failed = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first program piece: the pointer wraps below cell zero,
    // the cell wraps below zero and prints 0xFF, wraps back to zero, then a
    // read at end of input leaves it alone and a real read sets the low byte.
    push_load(OP_LEFT);
    push_load(OP_DEC);
    push_load(OP_PRINT);
    push_load(OP_INC);
    push_load(OP_READ);
    push_load(OP_READ);
    repeat (4) push_step_rand();
    push_step(8'hFF, 1'b0);
    push_step(8'h5A, 1'b1);

    // Second piece, loaded after stepping: the pointer wraps above the top
    // cell, an open bracket on a nonzero cell falls through, a close bracket
    // on a nonzero cell jumps back, a close bracket on a zero cell falls
    // through and an open bracket on a zero cell skips forward.
    push_load(OP_RIGHT);
    push_load(OP_INC);
    push_load(OP_OPEN);
    push_load(OP_LEFT);
    push_load(OP_CLOSE);
    push_load(OP_LEFT);
    push_load(OP_CLOSE);
    push_load(OP_OPEN);
    push_load(OP_CLOSE);
    repeat (8) push_step_rand();
    directed_total = items_queued;

    // Random part: load a balanced fragment, then run it. A run of fragments
    // in the middle goes with no idling on either side.
    blk = 0;
    while (items_queued < directed_total + RANDOM_ITEMS) begin
      steady_flow = (blk >= 10 && blk < 16);
      build_block();
      foreach (program_buf[i]) push_load(program_buf[i]);
      run_program(6 * program_buf.size() + 100);
      blk++;
    end
    steady_flow = 1'b0;

    // Closing phase. The sender holds off until every result is in, so the
    // interpreter state is exact before the last program goes in.
    wait_drained();
    run_program(5000);
    wait_drained();

    // If execution ran past the loaded bytes, pad up to the program counter.
    if (exec_pc > load_ptr) begin
      repeat (exec_pc - load_ptr) push_load(filler_byte());
    end

    // Walk to a zero cell, then an open bracket with no match anywhere after
    // it: the forward scan runs through the empty rest of the store, off its
    // end, and halts the block with the error flag.
    push_load(OP_OPEN);
    push_load(OP_RIGHT);
    push_load(OP_CLOSE);
    push_load(OP_OPEN);
    run_program(20000);

    // Steps once halted only report the state; a load still appends its byte.
    repeat (3) push_step_rand();
    push_load(8'hFF);
    push_step(8'hA5, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("brainfuck_interpreter_step test passed");
    end else begin
      $display("brainfuck_interpreter_step test failed");
    end
    $finish;
  end

endmodule
